// ===== sv/ctw_pkg.sv =====
package ctw_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int WILD_W   = 2;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // best-match wildcard count meaning "nothing matched yet"
    localparam logic [WILD_W-1:0] WILD_NONE = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] local_addr;
        logic [PORT_W-1:0] local_port;
        logic [ADDR_W-1:0] foreign_addr;
        logic [PORT_W-1:0] foreign_port;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic wr_en;    // write entry from the request ports
        logic clr_en;   // clear the valid bit of an entry
        logic load;     // capture a lookup request, reset the best match
        logic rd_en;    // read one table entry for comparison
    } ctw_cmd_t;

endpackage

// ===== sv/ctw_ram.sv =====
module ctw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ctw_ctrl.sv =====
module ctw_ctrl #(
    parameter int TABLE_ENTRIES = ctw_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ctw_pkg::KIND_W-1:0]       kind,
    output logic                             busy,
    output logic                             done,
    output ctw_pkg::ctw_cmd_t                cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr
);

    import ctw_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_LOOKUP))
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    always_comb
    begin
        cmd.wr_en  = accept && (kind == KIND_WRITE);
        cmd.clr_en = accept && (kind == KIND_CLEAR);
        cmd.load   = accept && (kind == KIND_LOOKUP);
        cmd.rd_en  = (state_reg == ST_SCAN);
    end

    assign rd_addr = scan_cnt_reg;
    assign busy    = (state_reg != ST_IDLE);
    assign done    = (state_reg == ST_DONE);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_LOOKUP)) |=> (busy && !done))
        else $error("lookup accepted without starting a scan");

    a_no_result_for_write: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind != KIND_LOOKUP)) |=> !busy)
        else $error("write or clear left the controller busy");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (cmd.rd_en && (rd_addr == '0)))
        else $error("scan did not begin at entry zero");

endmodule

// ===== sv/ctw_dp.sv =====
module ctw_dp #(
    parameter int TABLE_ENTRIES = ctw_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ctw_pkg::ctw_cmd_t                cmd,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
    input  logic [ctw_pkg::INDEX_W-1:0]      entry_index,
    input  logic [ctw_pkg::ADDR_W-1:0]       local_addr,
    input  logic [ctw_pkg::PORT_W-1:0]       local_port,
    input  logic [ctw_pkg::ADDR_W-1:0]       foreign_addr,
    input  logic [ctw_pkg::PORT_W-1:0]       foreign_port,
    input  logic                             allow_wildcard,
    output logic                             found,
    output logic [ctw_pkg::INDEX_W-1:0]      match_index,
    output logic [ctw_pkg::WILD_W-1:0]       wildcard_count
);

    import ctw_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     in_range;
    logic [IDX_W-1:0]         wr_idx;
    entry_t                   wr_entry;
    entry_t                   rd_entry;

    entry_t                   req_reg;
    logic                     allow_reg;

    logic                     eval_en_reg;
    logic                     eval_valid_reg;
    logic [IDX_W-1:0]         eval_idx_reg;

    logic [WILD_W-1:0]        best_wild_reg;
    logic [IDX_W-1:0]         best_idx_reg;

    logic                     l_ent_set, l_req_set, f_ent_set, f_req_set;
    logic                     l_bad, f_bad, port_ok;
    logic [WILD_W-1:0]        wild;
    logic                     hit;

    assign in_range = (32'(entry_index) < 32'(TABLE_ENTRIES));
    assign wr_idx   = IDX_W'(entry_index);

    always_comb
    begin
        wr_entry.local_addr   = local_addr;
        wr_entry.local_port   = local_port;
        wr_entry.foreign_addr = foreign_addr;
        wr_entry.foreign_port = foreign_port;
    end

    ctw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (cmd.wr_en && in_range),
        .waddr (wr_idx),
        .wdata (wr_entry),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (in_range && cmd.wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
        else if (in_range && cmd.clr_en)
        begin
            valid_reg[wr_idx] <= 1'b0;
        end
    end

    // hold the lookup key for the whole scan
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= wr_entry;
            allow_reg <= allow_wildcard;
        end
    end

    // align valid bit and index with the registered RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_en_reg    <= 1'b0;
            eval_valid_reg <= 1'b0;
            eval_idx_reg   <= '0;
        end
        else
        begin
            eval_en_reg    <= cmd.rd_en;
            eval_valid_reg <= valid_reg[rd_addr];
            eval_idx_reg   <= rd_addr;
        end
    end

    always_comb
    begin
        l_ent_set = (rd_entry.local_addr != '0);
        l_req_set = (req_reg.local_addr != '0);
        f_ent_set = (rd_entry.foreign_addr != '0);
        f_req_set = (req_reg.foreign_addr != '0);
        port_ok   = (rd_entry.local_port == req_reg.local_port);
        l_bad     = l_ent_set && l_req_set && (rd_entry.local_addr != req_reg.local_addr);
        f_bad     = f_ent_set && f_req_set
                    && ((rd_entry.foreign_addr != req_reg.foreign_addr)
                        || (rd_entry.foreign_port != req_reg.foreign_port));
        wild      = WILD_W'(l_ent_set ^ l_req_set) + WILD_W'(f_ent_set ^ f_req_set);
        hit       = eval_en_reg && eval_valid_reg && port_ok && !l_bad && !f_bad
                    && ((wild == '0) || allow_reg);
    end

    // strict compare keeps the lower index on a tie
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_wild_reg <= WILD_NONE;
            best_idx_reg  <= '0;
        end
        else if (cmd.load)
        begin
            best_wild_reg <= WILD_NONE;
            best_idx_reg  <= '0;
        end
        else if (hit && (wild < best_wild_reg))
        begin
            best_wild_reg <= wild;
            best_idx_reg  <= eval_idx_reg;
        end
    end

    assign found          = (best_wild_reg != WILD_NONE);
    assign match_index    = found ? INDEX_W'(best_idx_reg) : '0;
    assign wildcard_count = found ? best_wild_reg : '0;

    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.load && !$past(cmd.load)) |-> (best_wild_reg <= $past(best_wild_reg)))
        else $error("best wildcard count grew during a scan");

    a_eval_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> eval_en_reg)
        else $error("table read not followed by evaluation");

    a_found_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> (wildcard_count != WILD_NONE))
        else $error("match reported with no-match wildcard code");

endmodule

// ===== sv/connection_table_wildcard_lookup_top.sv =====
// Connection table with wildcard lookup.
//
// Input channel: present a transaction on the request ports with start high;
// it is taken at the rising edge where start is high and busy is low.
// kind selects lookup, write entry or clear entry; kind 3 is taken and dropped.
// Write and clear return nothing; busy stays low.
// A lookup reads the table one entry per cycle from a RAM with separate read
// and write ports and a registered read; busy is high from the accept to the
// end of its result cycle. The next transaction is taken only once busy is
// low again, so a new lookup never starts before the last one has returned
// its result.
// Result channel: done is high for exactly one cycle with found, match_index
// and wildcard_count valid in that cycle. The receiver cannot stall it.
// No match returns found, match_index and wildcard_count all zero.
// Reset clears every valid bit at once and returns the controller to idle; no
// clearing pass is needed, and an entry can only match once it is written.
module connection_table_wildcard_lookup_top #(
    parameter int TABLE_ENTRIES = ctw_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ctw_pkg::KIND_W-1:0]    kind,
    input  logic [ctw_pkg::INDEX_W-1:0]   entry_index,
    input  logic [ctw_pkg::ADDR_W-1:0]    local_addr,
    input  logic [ctw_pkg::PORT_W-1:0]    local_port,
    input  logic [ctw_pkg::ADDR_W-1:0]    foreign_addr,
    input  logic [ctw_pkg::PORT_W-1:0]    foreign_port,
    input  logic                          allow_wildcard,
    output logic                          done,
    output logic                          found,
    output logic [ctw_pkg::INDEX_W-1:0]   match_index,
    output logic [ctw_pkg::WILD_W-1:0]    wildcard_count
);

    import ctw_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    ctw_cmd_t         cmd;
    logic [IDX_W-1:0] rd_addr;

    ctw_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .kind    (kind),
        .busy    (busy),
        .done    (done),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    ctw_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .entry_index    (entry_index),
        .local_addr     (local_addr),
        .local_port     (local_port),
        .foreign_addr   (foreign_addr),
        .foreign_port   (foreign_port),
        .allow_wildcard (allow_wildcard),
        .found          (found),
        .match_index    (match_index),
        .wildcard_count (wildcard_count)
    );

endmodule
